// ===== rtl/bcdsm_pkg.sv =====
// Shared types and constants for the sign-magnitude BCD add/subtract block.
// No dependencies; used by every module in rtl/.
package bcdsm_pkg;

    localparam int DIGITS_DEF = 16;
    localparam int DIGITS_MAX = 16;
    localparam int NIBBLE_W   = 4;
    localparam int BUS_W      = DIGITS_MAX * NIBBLE_W;

    // per-digit decimal limits, sized for a digit sum with carry
    localparam logic [4:0] DEC_NINE = 5'd9;
    localparam logic [4:0] DEC_TEN  = 5'd10;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_LT  = 2'd2,
        OP_EQ  = 2'd3
    } t_op;

    typedef struct packed {
        logic [BUS_W-1:0] digits;
        logic             negative;
        logic             overflow;
        logic             less_than;
        logic             equal;
    } t_result;

endpackage

// ===== rtl/bcdsm_dec_add.sv =====
// Decimal magnitude adder: per-digit binary sums, carry chain resolved by
// one binary add over digit generate/propagate. Depends on bcdsm_pkg.
module bcdsm_dec_add #(
    parameter int DIGITS = bcdsm_pkg::DIGITS_DEF
) (
    input  logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] i_a,
    input  logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] i_b,
    output logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] o_sum,
    output logic                                  o_carry
);

    localparam int NW = bcdsm_pkg::NIBBLE_W;

    logic [4:0]        s0 [DIGITS];
    logic [DIGITS-1:0] gen;
    logic [DIGITS-1:0] gen_prop;
    logic [DIGITS:0]   chain;
    logic [DIGITS-1:0] cin;

    for (genvar i = 0; i < DIGITS; i++) begin : g_digit
        logic [4:0] s;
        assign s0[i]       = {1'b0, i_a[i*NW +: NW]} + {1'b0, i_b[i*NW +: NW]};
        assign gen[i]      = s0[i] > bcdsm_pkg::DEC_NINE;
        assign gen_prop[i] = gen[i] | (s0[i] == bcdsm_pkg::DEC_NINE);
        assign s           = s0[i] + {4'b0, cin[i]};
        always_comb begin
            if (s > bcdsm_pkg::DEC_NINE) begin
                o_sum[i*NW +: NW] = 4'(s - bcdsm_pkg::DEC_TEN);
            end else begin
                o_sum[i*NW +: NW] = s[3:0];
            end
        end
    end

    // binary carries of gen + (gen|prop) are exactly the decimal carries
    assign chain   = {1'b0, gen} + {1'b0, gen_prop};
    assign cin     = gen ^ gen_prop ^ chain[DIGITS-1:0];
    assign o_carry = chain[DIGITS];

endmodule

// ===== rtl/bcdsm_dec_sub.sv =====
// Decimal magnitude subtractor (big minus small), borrow chain resolved by
// one binary add over digit generate/propagate. Depends on bcdsm_pkg.
module bcdsm_dec_sub #(
    parameter int DIGITS = bcdsm_pkg::DIGITS_DEF
) (
    input  logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] i_big,
    input  logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] i_small,
    output logic [DIGITS*bcdsm_pkg::NIBBLE_W-1:0] o_diff
);

    localparam int NW = bcdsm_pkg::NIBBLE_W;

    logic [4:0]        d0 [DIGITS];
    logic [DIGITS-1:0] gen;
    logic [DIGITS-1:0] gen_prop;
    logic [DIGITS:0]   chain;
    logic [DIGITS-1:0] bin;

    for (genvar i = 0; i < DIGITS; i++) begin : g_digit
        logic [4:0] d;
        // two's complement, range -15..15
        assign d0[i]       = {1'b0, i_big[i*NW +: NW]} - {1'b0, i_small[i*NW +: NW]};
        assign gen[i]      = d0[i][4];
        assign gen_prop[i] = gen[i] | (d0[i] == 5'd0);
        assign d           = d0[i] - {4'b0, bin[i]};
        always_comb begin
            if (d[4]) begin
                o_diff[i*NW +: NW] = 4'(d + bcdsm_pkg::DEC_TEN);
            end else begin
                o_diff[i*NW +: NW] = d[3:0];
            end
        end
    end

    assign chain = {1'b0, gen} + {1'b0, gen_prop};
    assign bin   = gen ^ gen_prop ^ chain[DIGITS-1:0];

endmodule

// ===== rtl/bcdsm_core.sv =====
// Combinational datapath: sign handling, magnitude compare, decimal add and
// subtract, result select. Depends on bcdsm_pkg, bcdsm_dec_add, bcdsm_dec_sub.
module bcdsm_core #(
    parameter int DIGITS = bcdsm_pkg::DIGITS_DEF
) (
    input  bcdsm_pkg::t_op                 i_op,
    input  logic [bcdsm_pkg::BUS_W-1:0]    i_a_digits,
    input  logic                           i_a_negative,
    input  logic [bcdsm_pkg::BUS_W-1:0]    i_b_digits,
    input  logic                           i_b_negative,
    output bcdsm_pkg::t_result             o_result
);

    localparam int W = DIGITS * bcdsm_pkg::NIBBLE_W;

    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic         mag_gt;
    logic         mag_lt;
    logic         mag_eq;
    logic         b_eff;
    logic         like;
    logic [W-1:0] sum;
    logic         carry;
    logic [W-1:0] big;
    logic [W-1:0] small_mag;
    logic [W-1:0] diff;

    // digits above the top one are ignored
    assign a_mag = i_a_digits[W-1:0];
    assign b_mag = i_b_digits[W-1:0];

    // digit-wise compare from the top equals unsigned binary compare
    assign mag_gt = a_mag > b_mag;
    assign mag_lt = a_mag < b_mag;
    assign mag_eq = a_mag == b_mag;

    assign b_eff = (i_op == bcdsm_pkg::OP_SUB) ? ~i_b_negative : i_b_negative;
    assign like  = i_a_negative == b_eff;

    assign big       = mag_gt ? a_mag : b_mag;
    assign small_mag = mag_gt ? b_mag : a_mag;

    bcdsm_dec_add #(.DIGITS(DIGITS)) u_add (
        .i_a     (a_mag),
        .i_b     (b_mag),
        .o_sum   (sum),
        .o_carry (carry)
    );

    bcdsm_dec_sub #(.DIGITS(DIGITS)) u_sub (
        .i_big   (big),
        .i_small (small_mag),
        .o_diff  (diff)
    );

    always_comb begin
        o_result = '0;
        case (i_op)
            bcdsm_pkg::OP_ADD, bcdsm_pkg::OP_SUB: begin
                if (like) begin
                    if (carry) begin
                        // overflow code: minus zero
                        o_result.negative = 1'b1;
                        o_result.overflow = 1'b1;
                    end else begin
                        o_result.digits   = bcdsm_pkg::BUS_W'(sum);
                        o_result.negative = i_a_negative;
                    end
                end else if (!mag_eq) begin
                    o_result.digits   = bcdsm_pkg::BUS_W'(diff);
                    o_result.negative = mag_gt ? i_a_negative : ~i_a_negative;
                end
            end
            bcdsm_pkg::OP_LT: begin
                if (i_a_negative != i_b_negative) begin
                    o_result.less_than = i_a_negative;
                end else begin
                    o_result.less_than = i_a_negative ? mag_gt : mag_lt;
                end
            end
            bcdsm_pkg::OP_EQ: begin
                o_result.equal = (i_a_negative == i_b_negative) && mag_eq;
            end
            default: o_result = '0;
        endcase
    end

endmodule

// ===== rtl/bcd_sign_magnitude_add_sub_top.sv =====
// Top level of the sign-magnitude BCD add/subtract/compare block.
// Depends on bcdsm_pkg and bcdsm_core (with its adder and subtractor).
//
// Takes one beat per clock while o_in_stall is low and returns one result
// beat per input beat, in order. An accepted beat is held in an input
// register, passes through the single-pass decimal datapath and is
// captured in a result register, which drives the output. The clock
// period is set by the path from the input register through the
// magnitude compare, operand select and the DIGITS-wide borrow chain
// into the result register. Each stage holds its beat while the next one
// is full, so a new beat is still taken while a finished result waits on
// a stalled output. Result digits above DIGITS read zero.
module bcd_sign_magnitude_add_sub_top #(
    parameter int DIGITS = bcdsm_pkg::DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [bcdsm_pkg::BUS_W-1:0] i_a_digits,
    input  logic                        i_a_negative,
    input  logic [bcdsm_pkg::BUS_W-1:0] i_b_digits,
    input  logic                        i_b_negative,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bcdsm_pkg::BUS_W-1:0] o_result_digits,
    output logic                        o_result_negative,
    output logic                        o_overflow,
    output logic                        o_less_than,
    output logic                        o_equal
);

    logic                        r_in_valid;
    bcdsm_pkg::t_op              r_op;
    logic [bcdsm_pkg::BUS_W-1:0] r_a_digits;
    logic                        r_a_negative;
    logic [bcdsm_pkg::BUS_W-1:0] r_b_digits;
    logic                        r_b_negative;
    logic                        r_out_valid;
    bcdsm_pkg::t_result          r_result;
    bcdsm_pkg::t_result          n_result;

    logic out_free;
    logic stage_move;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign stage_move = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op         <= bcdsm_pkg::t_op'(i_operation);
            r_a_digits   <= i_a_digits;
            r_a_negative <= i_a_negative;
            r_b_digits   <= i_b_digits;
            r_b_negative <= i_b_negative;
        end
    end

    bcdsm_core #(.DIGITS(DIGITS)) u_core (
        .i_op         (r_op),
        .i_a_digits   (r_a_digits),
        .i_a_negative (r_a_negative),
        .i_b_digits   (r_b_digits),
        .i_b_negative (r_b_negative),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_digits   = r_result.digits;
    assign o_result_negative = r_result.negative;
    assign o_overflow        = r_result.overflow;
    assign o_less_than       = r_result.less_than;
    assign o_equal           = r_result.equal;

    // overflow always comes out as minus zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_result_negative && (o_result_digits == '0))
        else $error("overflow beat is not minus zero");

    // comparison beats carry no arithmetic result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_less_than || o_equal)
            |-> (o_result_digits == '0) && !o_result_negative && !o_overflow
            && !(o_less_than && o_equal))
        else $error("comparison beat mixes in arithmetic fields");

    // nibbles above the top digit stay zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_result_digits >> (DIGITS * bcdsm_pkg::NIBBLE_W)) == '0))
        else $error("result digits above top digit not zero");

    // input stalls only when both stages are full and the output is held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // a held result beat is not overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_result))
        else $error("stalled result register changed");

endmodule
